### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL. Each macro takes a
// label, the clock, the reset, the condition(s) and a message. Defining
// NO_ASSERTIONS compiles every use away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Item types for the non-uniform second derivative core.
// ----------------------------------------------------------------------------
`default_nettype none

package nsd_pkg;

  // One input point of a series, Q16.16 fixed point.
  typedef struct packed {
    logic               start_series;
    logic [31:0]        sample_volume;
    logic signed [31:0] sample_value;
  } sample_t;

  // One result item for the middle point of the window.
  typedef struct packed {
    logic [31:0]        center_volume;
    logic signed [31:0] second_derivative;
    logic               divide_fault;
  } result_t;

endpackage

`default_nettype wire

### rtl/nonuniform_second_derivative_core.sv
// ----------------------------------------------------------------------------
// Non-uniform second derivative core
// Three-point finite difference on a stream of (volume, value) points with
// uneven spacing, Q16.16 fixed point, built around one shared serial divider
// and one 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                    payload
//   sample    in          sample_valid / sample_ready  nsd_pkg::sample_t
//   result    out         result_valid / result_ready  nsd_pkg::result_t
//
// A point that opens a series or fills the window only moves the window on
// and gives no result. Every later point holds the input while the sequencer
// runs on the restoring divider (one quotient bit a cycle): 48 steps and a
// capture for each slope, the two products and their sum, 64 steps and a
// capture for the final quotient, and the load of the output register.
// A spacing of zero skips the arithmetic and loads a faulted zero result.
// Reset (rst, synchronous) empties the window and drops any pending result.
// A stalled result waits in the output register; the next point is taken
// meanwhile and the sequencer only holds once its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nonuniform_second_derivative_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire nsd_pkg::sample_t  sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output nsd_pkg::result_t       result
);

  localparam logic [6:0] SlopeSteps = 7'd48;
  localparam logic [6:0] FinalSteps = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_B,
    S_DIV_F,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_DIV_C,
    S_DONE
  } state_t;

  // Magnitude of a 33-bit signed difference of two 32-bit numbers.
  function automatic logic [31:0] abs33(input logic [32:0] d);
    logic [32:0] m;
    begin
      m = d[32] ? (~d + 33'd1) : d;
      return m[31:0];
    end
  endfunction

  // Apply a sign to a quotient magnitude and saturate to signed 32 bits.
  function automatic logic [31:0] sat_q(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    begin
      if (neg) begin
        r = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
      end else begin
        r = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return r;
    end
  endfunction

  state_t      state;
  logic [1:0]  held;

  // Window of the two previous points.
  logic [31:0] older_volume;
  logic [31:0] older_value;
  logic [31:0] middle_volume;
  logic [31:0] middle_value;

  // Operands captured when the third point arrives.
  logic [31:0] h1_mag, h2_mag, hh_mag;
  logic        h1_neg, h2_neg, hh_neg;
  logic [31:0] dyf_mag;
  logic        dyf_neg;
  logic [31:0] bw, fw;
  logic [63:0] ta_mag, tb_mag;
  logic        ta_neg, tb_neg;
  logic [31:0] center_vol;
  logic [31:0] deriv;
  logic        fault;

  // Shared divider: quotient/dividend shifter, partial remainder, divisor.
  logic [63:0] dq;
  logic [31:0] drem;
  logic [31:0] dden;
  logic [6:0]  dcnt;
  logic        quot_neg;

  logic        accept;
  logic [32:0] h1_d, h2_d, hh_d, dyb_d, dyf_d;
  logic        any_zero;
  logic [32:0] rem_sh, rem_sub;
  logic        rem_ge;
  logic [31:0] mul_a, mul_s, mul_b;
  logic [63:0] product;
  logic [64:0] sum_diff;
  logic [63:0] sum_num;
  logic        sum_neg;
  logic [31:0] quot_sat;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;

  // Spacings and value differences of the incoming window.
  assign h1_d  = {1'b0, sample.sample_volume} - {1'b0, middle_volume};
  assign h2_d  = {1'b0, middle_volume} - {1'b0, older_volume};
  assign hh_d  = {1'b0, sample.sample_volume} - {1'b0, older_volume};
  assign dyb_d = {middle_value[31], middle_value} - {older_value[31], older_value};
  assign dyf_d = {sample.sample_value[31], sample.sample_value}
               - {middle_value[31], middle_value};
  assign any_zero = (h1_d == 33'd0) || (h2_d == 33'd0) || (hh_d == 33'd0);

  // One restoring divide step; the remainder always stays below the divisor.
  assign rem_sh  = {drem, dq[63]};
  assign rem_ge  = (rem_sh >= {1'b0, dden});
  assign rem_sub = rem_sh - {1'b0, dden};
  assign quot_sat = sat_q(dq, quot_neg);

  // Shared multiplier: spacing magnitude times slope magnitude.
  assign mul_a   = (state == S_MUL_A) ? h1_mag : h2_mag;
  assign mul_s   = (state == S_MUL_A) ? bw : fw;
  assign mul_b   = mul_s[31] ? (~mul_s + 32'd1) : mul_s;
  assign product = {32'd0, mul_a} * {32'd0, mul_b};

  // Signed sum of the two weighted slope terms, as magnitude and sign.
  assign sum_diff = {1'b0, ta_mag} - {1'b0, tb_mag};
  always_comb begin
    priority if (ta_neg == tb_neg) begin
      sum_num = ta_mag + tb_mag;
      sum_neg = ta_neg;
    end else if (!sum_diff[64]) begin
      sum_num = sum_diff[63:0];
      sum_neg = ta_neg;
    end else begin
      sum_num = ~sum_diff[63:0] + 64'd1;
      sum_neg = tb_neg;
    end
  end

  // Sequencer, window, divider and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held         <= 2'd0;
      dcnt         <= 7'd0;
      result_valid <= 1'b0;
    end else begin
      // In the done state the output register is reloaded whenever it drains.
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (sample.start_series || held == 2'd0) begin
              older_volume  <= 32'd0;
              older_value   <= 32'd0;
              middle_volume <= sample.sample_volume;
              middle_value  <= sample.sample_value;
              held          <= 2'd1;
            end else begin
              older_volume  <= middle_volume;
              older_value   <= middle_value;
              middle_volume <= sample.sample_volume;
              middle_value  <= sample.sample_value;
              held          <= 2'd2;
              if (held == 2'd2) begin
                center_vol <= middle_volume;
                h1_mag     <= abs33(h1_d);
                h1_neg     <= h1_d[32];
                h2_mag     <= abs33(h2_d);
                h2_neg     <= h2_d[32];
                hh_mag     <= abs33(hh_d);
                hh_neg     <= hh_d[32];
                dyf_mag    <= abs33(dyf_d);
                dyf_neg    <= dyf_d[32];
                if (any_zero) begin
                  deriv <= 32'd0;
                  fault <= 1'b1;
                  state <= S_DONE;
                end else begin
                  fault    <= 1'b0;
                  dq       <= {abs33(dyb_d), 32'd0};
                  drem     <= 32'd0;
                  dden     <= abs33(h2_d);
                  dcnt     <= SlopeSteps;
                  quot_neg <= dyb_d[32] ^ h2_d[32];
                  state    <= S_DIV_B;
                end
              end
            end
          end
        end

        S_DIV_B, S_DIV_F, S_DIV_C: begin
          if (dcnt != 7'd0) begin
            drem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            dq   <= {dq[62:0], rem_ge};
            dcnt <= dcnt - 7'd1;
          end else if (state == S_DIV_B) begin
            // Backward slope done; start the forward slope.
            bw       <= quot_sat;
            dq       <= {dyf_mag, 32'd0};
            drem     <= 32'd0;
            dden     <= h1_mag;
            dcnt     <= SlopeSteps;
            quot_neg <= dyf_neg ^ h1_neg;
            state    <= S_DIV_F;
          end else if (state == S_DIV_F) begin
            fw    <= quot_sat;
            state <= S_MUL_A;
          end else begin
            deriv <= quot_sat;
            state <= S_DONE;
          end
        end

        S_MUL_A: begin
          ta_mag <= product;
          ta_neg <= h1_neg ^ bw[31];
          state  <= S_MUL_B;
        end

        S_MUL_B: begin
          tb_mag <= product;
          tb_neg <= h2_neg ^ fw[31];
          state  <= S_SUM;
        end

        S_SUM: begin
          dq       <= sum_num;
          drem     <= 32'd0;
          dden     <= hh_mag;
          dcnt     <= FinalSteps;
          quot_neg <= sum_neg ^ hh_neg;
          state    <= S_DIV_C;
        end

        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid             <= 1'b1;
            result.center_volume     <= center_vol;
            result.second_derivative <= deriv;
            result.divide_fault      <= fault;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A faulted result always carries a zero derivative.
  `ASSERT_IMPLIES(a_fault_zero, clk, rst, result_valid && result.divide_fault,
                  result.second_derivative == 32'sd0, "faulted result has nonzero derivative")

  // The divider step counter never runs past the longest division.
  `ASSERT_ALWAYS(a_dcnt_range, clk, rst, dcnt <= FinalSteps, "divider counter out of range")

  // A third point in a running series always starts the sequencer.
  `ASSERT_NEXT(a_third_busy, clk, rst,
               accept && !sample.start_series && held == 2'd2,
               state != S_IDLE, "third point did not start computation")

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the non-uniform second derivative core
// Sends series of (volume, value) points through the sample channel and
// checks every result item against a predictor that keeps its own copy of the
// three-point window. A short directed part covers the edges of the fields and
// the spacing faults. A longer random part of mostly well-formed series
// follows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_POINTS = 1300;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  nsd_pkg::sample_t sample       = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  nsd_pkg::result_t result;

  nonuniform_second_derivative_core u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Points waiting to be sent, and results the window predicts.
  nsd_pkg::sample_t points_to_send[$];
  nsd_pkg::result_t results_due[$];

  // Predictor copy of the window.
  logic [1:0]         held_points = 2'd0;
  logic [31:0]        older_vol   = '0;
  logic signed [31:0] older_val   = '0;
  logic [31:0]        mid_vol     = '0;
  logic signed [31:0] mid_val     = '0;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  logic        send_quiet  = 1'b0;
  logic        recv_quiet  = 1'b0;

  // Clock: 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 250);
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic longint clamp_s32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
    return v;
  endfunction

  // Weighted centre slope for the middle point of a full window.
  function automatic nsd_pkg::result_t centre_derivative(
    input logic [31:0] vo, input logic signed [31:0] yo,
    input logic [31:0] vm, input logic signed [31:0] ym,
    input logic [31:0] vn, input logic signed [31:0] yn);
    longint           h_fwd, h_bwd, h_out, slope_bwd, slope_fwd, term_a, term_b;
    logic [63:0]      mag_a, mag_b, num, mag_out, quo;
    logic             num_neg;
    nsd_pkg::result_t r;
    h_fwd = $signed({32'd0, vn}) - $signed({32'd0, vm});
    h_bwd = $signed({32'd0, vm}) - $signed({32'd0, vo});
    h_out = $signed({32'd0, vn}) - $signed({32'd0, vo});
    r.center_volume     = vm;
    r.second_derivative = '0;
    r.divide_fault      = (h_fwd == 0) || (h_bwd == 0) || (h_out == 0);
    if (!r.divide_fault) begin
      // Slopes in Q16.16, truncated toward zero and saturated.
      slope_bwd = clamp_s32(((longint'(ym) - longint'(yo)) * 65536) / h_bwd);
      slope_fwd = clamp_s32(((longint'(yn) - longint'(ym)) * 65536) / h_fwd);
      term_a    = h_fwd * slope_bwd;
      term_b    = h_bwd * slope_fwd;
      mag_a     = (term_a < 0) ? -term_a : term_a;
      mag_b     = (term_b < 0) ? -term_b : term_b;
      // Sign and magnitude sum, since the exact sum can need 64 bits.
      if ((term_a < 0) == (term_b < 0)) begin
        num     = mag_a + mag_b;
        num_neg = term_a < 0;
      end else if (mag_a >= mag_b) begin
        num     = mag_a - mag_b;
        num_neg = term_a < 0;
      end else begin
        num     = mag_b - mag_a;
        num_neg = term_b < 0;
      end
      mag_out = (h_out < 0) ? -h_out : h_out;
      quo     = num / mag_out;
      if (num_neg != (h_out < 0)) begin
        r.second_derivative = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'd0 - quo[31:0];
      end else begin
        r.second_derivative = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
      end
    end
    return r;
  endfunction

  // Moves the window on by one accepted point and records any result due.
  task automatic advance_window(input nsd_pkg::sample_t pt);
    if (pt.start_series || held_points == 2'd0) begin
      older_vol   = '0;
      older_val   = '0;
      held_points = 2'd1;
    end else begin
      if (held_points == 2'd2) begin
        results_due.push_back(centre_derivative(older_vol, older_val, mid_vol, mid_val,
                                                pt.sample_volume, pt.sample_value));
      end
      older_vol   = mid_vol;
      older_val   = mid_val;
      held_points = 2'd2;
    end
    mid_vol = pt.sample_volume;
    mid_val = pt.sample_value;
  endtask

  // Compares one result item with the oldest prediction.
  task automatic check_result(input nsd_pkg::result_t got);
    nsd_pkg::result_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("cycle %0d: result with none due: volume %h derivative %h fault %b",
                 cycle_count, got.center_volume, got.second_derivative, got.divide_fault);
      end
    end else begin
      want = results_due.pop_front();
      if (got.center_volume !== want.center_volume ||
          got.second_derivative !== want.second_derivative ||
          got.divide_fault !== want.divide_fault) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("cycle %0d: volume exp %h got %h, derivative exp %h got %h, fault exp %b got %b",
                   cycle_count, want.center_volume, got.center_volume,
                   want.second_derivative, got.second_derivative,
                   want.divide_fault, got.divide_fault);
        end
      end
    end
  endtask

  task automatic queue_point(input logic start, input logic [31:0] vol,
                             input logic [31:0] val);
    nsd_pkg::sample_t pt;
    pt.start_series  = start;
    pt.sample_volume = vol;
    pt.sample_value  = val;
    points_to_send.push_back(pt);
  endtask

  // Sample driver: presents the next point once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        advance_window(sample);
      end
      if (!sample_valid || sample_ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          sample_valid <= 1'b0;
        end else if (points_to_send.size() != 0) begin
          sample       <= points_to_send.pop_front();
          sample_valid <= 1'b1;
          send_gap     <= pick_gap(send_quiet);
          if ($urandom_range(0, 49) == 0) send_quiet <= !send_quiet;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks taken items and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && result_ready) begin
        check_result(result);
      end
      if (stall_left != 0) begin
        result_ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!recv_quiet && $urandom_range(0, 9) == 0) begin
        result_ready <= 1'b0;
        stall_left   <= pick_gap(1'b0);
      end else begin
        result_ready <= 1'b1;
      end
      if ($urandom_range(0, 1999) == 0) recv_quiet <= !recv_quiet;
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0]        vol;
    logic [31:0]        step;
    logic signed [31:0] val;
    int unsigned        len;
    int unsigned        roll;
    int unsigned        scale;
    int unsigned        queued;
    logic               falling;
    logic               rough;

    // First point after reset without a start flag, then a plain curve.
    queue_point(1'b0, 32'h0001_0000, 32'h0000_0000);
    queue_point(1'b0, 32'h0002_0000, 32'h0001_0000);
    queue_point(1'b0, 32'h0003_0000, 32'h0004_0000);
    // Start mid-series at the field extremes, with the last volume falling.
    queue_point(1'b1, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_point(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_point(1'b0, 32'h0000_0001, 32'h7FFF_FFFF);
    // Forward spacing zero, backward spacing zero, outer spacing zero.
    queue_point(1'b0, 32'h0000_0001, 32'h1234_5678);
    queue_point(1'b0, 32'h0000_0002, 32'hEDCB_A987);
    queue_point(1'b0, 32'h0000_0001, 32'h0000_0100);
    // Falling volumes with unit steps.
    queue_point(1'b0, 32'h0000_0000, 32'hFFFF_0000);
    // Full-scale swings across the volume range.
    queue_point(1'b1, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_point(1'b0, 32'hFFFF_0000, 32'h7FFF_FFFF);
    queue_point(1'b0, 32'h0000_0000, 32'h8000_0000);
    queue_point(1'b0, 32'h0000_0010, 32'h7FFF_FFFF);
    // Unit spacings with opposite saturated slopes.
    queue_point(1'b1, 32'h0010_0000, 32'hFFFF_FFFB);
    queue_point(1'b0, 32'h0010_0001, 32'h7FFF_FFFF);
    queue_point(1'b0, 32'h0010_0002, 32'h8000_0000);
    queue_point(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_point(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
    // Back-to-back starts, then a short series.
    queue_point(1'b1, 32'h0000_0005, 32'h0000_0001);
    queue_point(1'b1, 32'h0000_0006, 32'h0000_0002);
    queue_point(1'b0, 32'h0000_0007, 32'h0000_0004);
    queue_point(1'b0, 32'h0000_0008, 32'h0000_0008);

    // Random part: mostly well-formed series, some loose noise.
    queued = 0;
    while (queued < RANDOM_POINTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 82) begin
        len     = $urandom_range(2, 40);
        falling = ($urandom_range(0, 6) == 0);
        rough   = ($urandom_range(0, 3) == 0);
        scale   = $urandom_range(0, 2);
        vol     = $urandom;
        val     = $urandom;
        for (int i = 0; i < len; i++) begin
          queue_point(i == 0, vol, val);
          case (scale)
            0: begin
              step = $urandom_range(1, 16);
            end
            1: begin
              step = $urandom_range(1, 32'h0004_0000);
            end
            default: begin
              step = $urandom_range(1, 32'h1000_0000);
            end
          endcase
          // Now and then a repeated volume.
          if ($urandom_range(0, 49) == 0) step = '0;
          vol = falling ? vol - step : vol + step;
          if (rough) begin
            val = $urandom;
          end else begin
            val = val + 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
          end
        end
        queued += len;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          queue_point($urandom_range(0, 3) == 0, $urandom, $urandom);
        end
        queued += len;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sampled on the falling edge, away from the driver and monitor.
    while (points_to_send.size() != 0 || sample_valid) @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/nsd_pkg.sv
rtl/nonuniform_second_derivative_core.sv
bench/tb_top.sv
